### hw/rtl/clrc_pkg.sv
package clrc_pkg;

    localparam int TEXT_LEN = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 8;

    localparam logic [CNT_W-1:0] TEXT_LEN_CNT = CNT_W'(TEXT_LEN);
    localparam logic [CNT_W-1:0] CURSOR_ROW_LEN = 8'd16;

    localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0F;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_CURSOR    = 8'h80;
    localparam logic [7:0] CMD_CURSOR_HI = 8'hBF;

    localparam logic [7:0] PWR_WAIT_RST = 8'd10;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_INIT1   = 4'd1,
        PH_WAIT    = 4'd2,
        PH_C38     = 4'd3,
        PH_C06     = 4'd4,
        PH_C0F     = 4'd5,
        PH_C01     = 4'd6,
        PH_IDLE    = 4'd7,
        PH_CLR     = 4'd8,
        PH_POS     = 4'd9,
        PH_CHAR    = 4'd10,
        PH_WAITGO0 = 4'd11
    } phase_t;

endpackage

### hw/rtl/clrc_in_if.sv
interface clrc_in_if
    import clrc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             action;
    logic             go;
    logic [IDX_W-1:0] char_index;
    logic [7:0]       char_value;

    modport source (output valid, action, go, char_index, char_value, input ready);
    modport sink   (input valid, action, go, char_index, char_value, output ready);
endinterface

### hw/rtl/clrc_out_if.sv
interface clrc_out_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable_pin;
    logic [7:0] data_bus;
    logic       enable_dropped;
    logic       ready_res;

    modport source (output valid, reg_select, enable_pin, data_bus, enable_dropped, ready_res,
                    input ready);
    modport sink   (input valid, reg_select, enable_pin, data_bus, enable_dropped, ready_res,
                    output ready);
endinterface

### hw/rtl/char_lcd_refresh_controller_top.sv
// channel   | dir | handshake   | payload
// ----------+-----+-------------+-------------------------------------------------
// in_ch     | in  | valid/ready | action, go, char_index[3:0], char_value[7:0]
// out_ch    | out | valid/ready | reg_select, enable_pin, data_bus[7:0],
//           |     |             | enable_dropped, ready_res
// cfg       | in  | cfg_we      | cfg_wdata[7:0] -> power-up wait
//
// one transaction per clock while in_ch.ready is high: a tick steps the controller at
// input accept and the result lands in the result register, so it appears in the next cycle
// in_ch.ready is high while the result register is empty or being drained
// reset clears phase, counters, pin levels, text store and result valid
// a stalled result holds; no input is taken until it leaves
module char_lcd_refresh_controller_top
    import clrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    clrc_in_if.sink    in_ch,
    clrc_out_if.source out_ch
);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] step_count_reg, step_count_next, sc_mid;
    logic             rs_reg, rs_next;
    logic             e_reg, e_next;
    logic [7:0]       bus_reg, bus_next;
    logic             ready_reg, ready_next, ready_mid;
    logic             dropped;
    logic [7:0]       pwr_wait_reg;
    logic [7:0]       text_reg [TEXT_LEN];

    logic             out_valid_reg;
    logic             res_rs_reg, res_e_reg, res_drop_reg, res_ready_reg;
    logic [7:0]       res_bus_reg;

    logic             in_acc, tick, wr;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign tick        = in_acc && (in_ch.action == ACT_TICK);
    assign wr          = in_acc && (in_ch.action == ACT_WRITE);

    // transition out of the current phase
    always_comb
    begin
        phase_next = phase_reg;
        dropped    = 1'b0;
        sc_mid     = step_count_reg;
        ready_mid  = ready_reg;
        unique case (phase_reg)
            PH_INIT1:
            begin
                phase_next = PH_WAIT;
                sc_mid     = '0;
            end
            PH_WAIT:
                phase_next = (step_count_reg < pwr_wait_reg) ? PH_WAIT : PH_C38;
            PH_C38:
            begin
                phase_next = PH_C06;
                dropped    = 1'b1;
            end
            PH_C06:
            begin
                phase_next = PH_C0F;
                dropped    = 1'b1;
            end
            PH_C0F:
            begin
                phase_next = PH_C01;
                dropped    = 1'b1;
            end
            PH_C01:
            begin
                phase_next = PH_IDLE;
                dropped    = 1'b1;
            end
            PH_IDLE:
            begin
                if (in_ch.go)
                begin
                    ready_mid  = 1'b0;
                    phase_next = PH_CLR;
                end
            end
            PH_CLR:
            begin
                phase_next = PH_POS;
                dropped    = 1'b1;
                sc_mid     = '0;
            end
            PH_POS:
            begin
                phase_next = PH_CHAR;
                dropped    = 1'b1;
            end
            PH_CHAR:
            begin
                dropped    = 1'b1;
                sc_mid     = step_count_reg + 1'b1;
                phase_next = (sc_mid < TEXT_LEN_CNT) ? PH_POS : PH_WAITGO0;
            end
            PH_WAITGO0:
                phase_next = in_ch.go ? PH_WAITGO0 : PH_IDLE;
            default:
                phase_next = PH_INIT1;
        endcase
    end

    // pin and counter actions on entering the new phase
    always_comb
    begin
        step_count_next = sc_mid;
        rs_next         = rs_reg;
        e_next          = dropped ? 1'b0 : e_reg;
        bus_next        = bus_reg;
        ready_next      = ready_mid;
        unique case (phase_next) inside
            PH_INIT1:
                ready_next = 1'b0;
            PH_WAIT:
                step_count_next = sc_mid + 1'b1;
            PH_C38:
            begin
                rs_next  = RS_CMD;
                bus_next = CMD_FUNC_SET;
                e_next   = 1'b1;
            end
            PH_C06:
            begin
                rs_next  = RS_CMD;
                bus_next = CMD_ENTRY;
                e_next   = 1'b1;
            end
            PH_C0F:
            begin
                rs_next  = RS_CMD;
                bus_next = CMD_DISP_ON;
                e_next   = 1'b1;
            end
            PH_C01, PH_CLR:
            begin
                rs_next  = RS_CMD;
                bus_next = CMD_CLEAR;
                e_next   = 1'b1;
            end
            PH_IDLE:
                ready_next = 1'b1;
            PH_POS:
            begin
                rs_next  = RS_CMD;
                bus_next = (sc_mid < CURSOR_ROW_LEN) ? (CMD_CURSOR + sc_mid)
                                                     : (CMD_CURSOR_HI + sc_mid);
                e_next   = 1'b1;
            end
            PH_CHAR:
            begin
                rs_next  = RS_DATA;
                bus_next = (sc_mid < TEXT_LEN_CNT) ? text_reg[sc_mid[IDX_W-1:0]] : 8'd0;
                e_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            step_count_reg <= '0;
            rs_reg         <= 1'b0;
            e_reg          <= 1'b0;
            bus_reg        <= '0;
            ready_reg      <= 1'b0;
        end
        else if (tick)
        begin
            phase_reg      <= phase_next;
            step_count_reg <= step_count_next;
            rs_reg         <= rs_next;
            e_reg          <= e_next;
            bus_reg        <= bus_next;
            ready_reg      <= ready_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwr_wait_reg <= PWR_WAIT_RST;
        end
        else if (cfg_we)
        begin
            pwr_wait_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TEXT_LEN; i++)
            begin
                text_reg[i] <= '0;
            end
        end
        else if (wr)
        begin
            text_reg[in_ch.char_index] <= in_ch.char_value;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            res_rs_reg    <= tick ? rs_next    : rs_reg;
            res_e_reg     <= tick ? e_next     : e_reg;
            res_bus_reg   <= tick ? bus_next   : bus_reg;
            res_drop_reg  <= tick ? dropped    : 1'b0;
            res_ready_reg <= tick ? ready_next : ready_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.reg_select     = res_rs_reg;
    assign out_ch.enable_pin     = res_e_reg;
    assign out_ch.data_bus       = res_bus_reg;
    assign out_ch.enable_dropped = res_drop_reg;
    assign out_ch.ready_res      = res_ready_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg == (phase_reg == PH_IDLE))
        else $error("ready flag out of step with idle phase");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_POS || phase_reg == PH_CHAR) |-> (step_count_reg < TEXT_LEN_CNT))
        else $error("text position past end of store");

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("stalled result dropped");

endmodule
